// ----- sv/acre_pkg.sv -----
// Shared types and constants for the alignment CIGAR run encoder.
package acre_pkg;

    // CIGAR operation codes carried on the result channel
    typedef enum logic [2:0] {
        OP_CLIP  = 3'd0,
        OP_INS   = 3'd1,
        OP_DEL   = 3'd2,
        OP_MATCH = 3'd3,
        OP_MISM  = 3'd4,
        OP_SKIP  = 3'd5
    } t_op_code;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_QUERY_LENGTH = 2'd0,
        REG_QUERY_START  = 2'd1,
        REG_QUERY_END    = 2'd2,
        REG_ALIGN_LENGTH = 2'd3
    } t_reg_index;

    localparam logic [7:0]  GAP_BYTE  = 8'd45;
    localparam logic [15:0] SKIP_MIN  = 16'd100;
    localparam logic [15:0] COUNT_CAP = 16'hFFFF;

    // Result queue geometry: one column emits at most three operations
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_AW      = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW      = $clog2(Q_DEPTH + 1);
    localparam int unsigned MAX_OPS   = 3;

    // One CIGAR operation
    typedef struct packed {
        t_op_code    op_code;
        logic [15:0] op_length;
        logic        last_op;
    } t_op;

    // Operations produced by one column, in order; cnt of them are valid
    typedef struct packed {
        logic [1:0]           cnt;
        t_op [MAX_OPS-1:0]    ops;
    } t_push;

endpackage

// ----- sv/acre_run_track.sv -----
// Column input register, run tracking and per-column operation formation.
module acre_run_track
    import acre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_query_char,
    input  logic [7:0]  i_subject_char,
    input  logic        i_last_column,
    input  logic        i_room,
    output t_push       o_push
);

    logic [15:0] r_query_length;
    logic [15:0] r_query_start;
    logic [15:0] r_query_end;
    logic [15:0] r_align_length;

    logic        r_vld;
    logic [7:0]  r_q;
    logic [7:0]  r_s;
    logic        r_last;

    t_op_code    r_class;
    logic [15:0] r_count;
    logic        r_seen;

    logic        fire;
    logic        accept;
    t_op_code    cls;
    logic        cont;
    logic        len_cond;
    logic        lead;
    logic        flush;
    logic        trail;
    logic [16:0] trail_diff;
    t_op_code    n_class;
    logic [15:0] n_count;
    t_push       push;

    function automatic t_op_code classify(input logic [7:0] q, input logic [7:0] s);
        t_op_code c;
        if (s == GAP_BYTE) c = OP_INS;
        else if (q == GAP_BYTE) c = OP_DEL;
        else if (q == s) c = OP_MATCH;
        else c = OP_MISM;
        return c;
    endfunction

    function automatic logic continues(input t_op_code c, input logic [7:0] q,
                                       input logic [7:0] s);
        logic r;
        case (c)
            OP_INS:   r = (s == GAP_BYTE);
            OP_DEL:   r = (q == GAP_BYTE);
            OP_MATCH: r = (q == s);
            OP_MISM:  r = (s != GAP_BYTE) && (q != GAP_BYTE) && (q != s);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_op run_op(input t_op_code c, input logic [15:0] n);
        t_op o;
        o.op_code   = (c == OP_DEL && n >= SKIP_MIN) ? OP_SKIP : c;
        o.op_length = n;
        o.last_op   = 1'b0;
        return o;
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_length <= '0;
            r_query_start  <= 16'd1;
            r_query_end    <= '0;
            r_align_length <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_QUERY_LENGTH: r_query_length <= i_cfg_data;
                REG_QUERY_START:  r_query_start  <= i_cfg_data;
                REG_QUERY_END:    r_query_end    <= i_cfg_data;
                REG_ALIGN_LENGTH: r_align_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advances when the queue can take a full column's worth of operations
    assign fire    = r_vld && i_room;
    assign o_ready = !r_vld || i_room;
    assign accept  = i_valid && o_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q    <= i_query_char;
            r_s    <= i_subject_char;
            r_last <= i_last_column;
        end
    end

    // Classify the column and decide which operations it closes
    always_comb begin
        cls        = classify(r_q, r_s);
        cont       = r_seen && continues(r_class, r_q, r_s);
        len_cond   = r_query_length > r_align_length;
        lead       = !r_seen && len_cond && (r_query_start > 16'd1);
        flush      = r_seen && !cont;
        trail_diff = {1'b0, r_query_length} - {1'b0, r_query_end};
        trail      = r_last && len_cond && ($signed(trail_diff) > 17'sd1);
        n_class    = cont ? r_class : cls;
        if (!cont) n_count = 16'd1;
        else if (r_count < COUNT_CAP) n_count = r_count + 16'd1;
        else n_count = r_count;
    end

    // Pack the operations in stream order
    always_comb begin
        push     = '0;
        push.cnt = 2'd0;
        if (lead) begin
            push.ops[push.cnt].op_code   = OP_CLIP;
            push.ops[push.cnt].op_length = r_query_start - 16'd1;
            push.ops[push.cnt].last_op   = 1'b0;
            push.cnt = push.cnt + 2'd1;
        end
        if (flush) begin
            push.ops[push.cnt] = run_op(r_class, r_count);
            push.cnt = push.cnt + 2'd1;
        end
        if (r_last) begin
            push.ops[push.cnt]         = run_op(n_class, n_count);
            push.ops[push.cnt].last_op = !trail;
            push.cnt = push.cnt + 2'd1;
        end
        if (trail) begin
            push.ops[push.cnt].op_code   = OP_CLIP;
            push.ops[push.cnt].op_length = trail_diff[15:0];
            push.ops[push.cnt].last_op   = 1'b1;
            push.cnt = push.cnt + 2'd1;
        end
        if (!fire) push.cnt = 2'd0;
    end

    assign o_push = push;

    // Run state; drop back to no-column after the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= OP_CLIP;
            r_count <= '0;
            r_seen  <= 1'b0;
        end else if (fire) begin
            if (r_last) begin
                r_class <= OP_CLIP;
                r_count <= '0;
                r_seen  <= 1'b0;
            end else begin
                r_class <= n_class;
                r_count <= n_count;
                r_seen  <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |-> o_push.cnt != 2'd0)
        else $error("last column produced no operation");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> !r_seen && r_count == 16'd0)
        else $error("run state not cleared after last column");
    a_open_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> r_count != 16'd0)
        else $error("open run with zero length");
`endif

endmodule

// ----- sv/acre_op_queue.sv -----
// Small result queue that serializes up to three operations per column.
module acre_op_queue
    import acre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_ready,
    output t_op         o_op
);

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            pop;

    assign o_valid = r_count != '0;
    assign pop     = o_valid && i_ready;
    assign o_op    = r_mem[r_rd_ptr];
    assign o_room  = r_count <= Q_CW'(Q_DEPTH - MAX_OPS);
    assign n_count = r_count + Q_CW'(i_push.cnt) - Q_CW'(pop);

    // Write the column's operations at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_OPS; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[r_wr_ptr + Q_AW'(k)] <= i_push.ops[k];
            end
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_AW'(i_push.cnt);
            if (pop) r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("push without room");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.cnt == 2'd0 |=> r_count == $past(r_count) - Q_CW'(1))
        else $error("occupancy did not drop on pop");
`endif

endmodule

// ----- sv/alignment_cigar_run_encoder.sv -----
// Top level of the alignment CIGAR run encoder.
// Usage:
//   Input channel (i_valid / o_ready) carries one alignment column per
//   transaction: query byte, subject byte and a last-column mark.
//   Output channel (o_valid / i_ready) carries one CIGAR operation per
//   transaction: op code, run or clip length, and a final-operation mark.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   the user must write it only while no column is in flight; the block does not enforce this.
// Path: an accepted column is held in the input register until the queue has
//   room, then its operations are written into the result queue.
// Throughput: one column per cycle while each column yields at most one
//   operation and i_ready is high; a column that yields two or three (leading
//   clip, final run, trailing clip) holds the input while the four-entry
//   result queue drains.
// Stall: when i_ready is low the queue fills and, while a column is held,
//   o_ready drops once the queue holds more than one operation; nothing is lost.
// Reset: synchronous, active low; clears the run state and the queue and
//   loads the register defaults (query start 1, others 0).
module alignment_cigar_run_encoder
    import acre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_query_char,
    input  logic [7:0]  i_subject_char,
    input  logic        i_last_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_op_code,
    output logic [15:0] o_op_length,
    output logic        o_last_op
);

    t_push push;
    logic  room;
    t_op   op;

    // Column stage and run tracking
    acre_run_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_query_char   (i_query_char),
        .i_subject_char (i_subject_char),
        .i_last_column  (i_last_column),
        .i_room         (room),
        .o_push         (push)
    );

    // Result queue
    acre_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_op    (op)
    );

    assign o_op_code   = op.op_code;
    assign o_op_length = op.op_length;
    assign o_last_op   = op.last_op;

endmodule

// ----- sim/alignment_cigar_run_encoder_test.sv -----
// Self-checking testbench for the alignment CIGAR run encoder.
`timescale 1ns / 100ps

module alignment_cigar_run_encoder_test;
    import acre_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_COLS   = 25;

    // Shapes of generated alignment columns
    typedef enum {
        COL_MATCH,
        COL_MISM,
        COL_INS,
        COL_DEL,
        COL_BOTH_GAP,
        COL_NOISE
    } t_col_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_query_char;
    logic [7:0]  i_subject_char;
    logic        i_last_column;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_op_code;
    logic [15:0] o_op_length;
    logic        o_last_op;

    // Register copies and run state of the CIGAR predictor
    logic [15:0] cfg_qlen;
    logic [15:0] cfg_qstart;
    logic [15:0] cfg_qend;
    logic [15:0] cfg_alen;
    t_op_code    run_kind;
    logic [15:0] run_len;
    bit          in_alignment;

    // Expected CIGAR operations, oldest first
    t_op expected_cigar[$];
    t_op checked_op;

    int  errors = 0;
    int  cycles = 0;
    int  columns_sent;
    int  ops_checked = 0;
    int  alignments_done;
    int  settings_applied;
    bit  src_gaps_on;
    bit  sink_stalls_on;
    int  stall_left = 0;
    int  calm_left = 0;
    int  sink_gap;

    alignment_cigar_run_encoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_query_char   (i_query_char),
        .i_subject_char (i_subject_char),
        .i_last_column  (i_last_column),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_op_code      (o_op_code),
        .o_op_length    (o_op_length),
        .o_last_op      (o_last_op)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] residue();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == GAP_BYTE);
        return b;
    endfunction

    // Register values biased toward the extremes
    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(0, 300));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_op_code column_kind(input logic [7:0] q, input logic [7:0] s);
        if (s == GAP_BYTE) return OP_INS;
        if (q == GAP_BYTE) return OP_DEL;
        if (q == s) return OP_MATCH;
        return OP_MISM;
    endfunction

    // A column continues an open run when it passes the test of the run's own kind
    function automatic bit extends_run(input t_op_code kind, input logic [7:0] q,
                                       input logic [7:0] s);
        case (kind)
            OP_INS:   return s == GAP_BYTE;
            OP_DEL:   return q == GAP_BYTE;
            OP_MATCH: return q == s;
            OP_MISM:  return s != GAP_BYTE && q != GAP_BYTE && q != s;
            default:  return 1'b0;
        endcase
    endfunction

    // Close the open run; long deletions become skips
    function automatic t_op closed_run();
        t_op op;
        op.op_code   = (run_kind == OP_DEL && run_len >= SKIP_MIN) ? OP_SKIP : run_kind;
        op.op_length = run_len;
        op.last_op   = 1'b0;
        return op;
    endfunction

    // Predict the operations that one accepted column produces
    task automatic encode_column(input logic [7:0] q, input logic [7:0] s, input logic last);
        t_op ops[$];
        t_op op;
        int  trail;
        op.last_op = 1'b0;
        if (!in_alignment) begin
            if (cfg_qlen > cfg_alen && cfg_qstart > 16'd1) begin
                op.op_code   = OP_CLIP;
                op.op_length = cfg_qstart - 16'd1;
                ops.push_back(op);
            end
            run_kind     = column_kind(q, s);
            run_len      = 16'd1;
            in_alignment = 1'b1;
        end else if (extends_run(run_kind, q, s)) begin
            if (run_len < COUNT_CAP) run_len++;
        end else begin
            ops.push_back(closed_run());
            run_kind = column_kind(q, s);
            run_len  = 16'd1;
        end
        if (last) begin
            ops.push_back(closed_run());
            trail = int'(cfg_qlen) - int'(cfg_qend);
            if (cfg_qlen > cfg_alen && trail > 1) begin
                op.op_code   = OP_CLIP;
                op.op_length = cfg_qlen - cfg_qend;
                ops.push_back(op);
            end
            ops[ops.size() - 1].last_op = 1'b1;
            run_kind     = OP_CLIP;
            run_len      = 16'd0;
            in_alignment = 1'b0;
            alignments_done++;
        end
        foreach (ops[i]) expected_cigar.push_back(ops[i]);
    endtask

    // Send one column and hold it until the transaction completes
    task automatic send_column(input logic [7:0] q, input logic [7:0] s, input logic last);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_query_char   <= q;
        i_subject_char <= s;
        i_last_column  <= last;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_column(q, s, last);
        columns_sent++;
    endtask

    // Send count columns of one shape, marking the final one last if asked
    task automatic send_run(input t_col_shape shape, input int count, input bit last);
        logic [7:0] q;
        logic [7:0] s;
        for (int i = 0; i < count; i++) begin
            case (shape)
                COL_MATCH: begin
                    q = residue();
                    s = q;
                end
                COL_MISM: begin
                    q = residue();
                    do s = residue(); while (s == q);
                end
                COL_INS: begin
                    q = residue();
                    s = GAP_BYTE;
                end
                COL_DEL: begin
                    q = GAP_BYTE;
                    s = residue();
                end
                COL_BOTH_GAP: begin
                    q = GAP_BYTE;
                    s = GAP_BYTE;
                end
                default: begin
                    q = ($urandom_range(0, 3) == 0) ? GAP_BYTE : 8'($urandom_range(0, 255));
                    s = ($urandom_range(0, 3) == 0) ? GAP_BYTE : 8'($urandom_range(0, 255));
                end
            endcase
            send_column(q, s, last && (i == count - 1));
        end
    endtask

    // Drop valid and drain every expected operation, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_cigar.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_QUERY_LENGTH: cfg_qlen   = data;
            REG_QUERY_START:  cfg_qstart = data;
            REG_QUERY_END:    cfg_qend   = data;
            REG_ALIGN_LENGTH: cfg_alen   = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] qlen, input logic [15:0] qstart,
                                 input logic [15:0] qend, input logic [15:0] alen);
        settle();
        write_reg(REG_QUERY_LENGTH, qlen);
        write_reg(REG_QUERY_START, qstart);
        write_reg(REG_QUERY_END, qend);
        write_reg(REG_ALIGN_LENGTH, alen);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Register defaults: no clips, every run kind, byte extremes
    task automatic test_reset_defaults();
        send_column(8'd0, 8'd0, 1'b0);
        send_column(8'd255, 8'd255, 1'b0);
        send_run(COL_MATCH, 1, 1'b0);
        send_column(8'd255, 8'd0, 1'b0);
        send_run(COL_INS, 2, 1'b0);
        send_run(COL_DEL, 1, 1'b1);
    endtask

    // Double-gap columns: extend deletion and match runs, start insertions
    task automatic test_gap_rules();
        apply_setting(16'd200, 16'd11, 16'd150, 16'd120);
        send_column(GAP_BYTE, GAP_BYTE, 1'b1);
        send_column(8'd0, 8'd0, 1'b0);
        send_column(GAP_BYTE, GAP_BYTE, 1'b0);
        send_column(8'd255, 8'd255, 1'b0);
        send_column(GAP_BYTE, 8'hC3, 1'b0);
        send_column(GAP_BYTE, GAP_BYTE, 1'b0);
        send_column(8'd255, 8'd0, 1'b0);
        send_column(GAP_BYTE, GAP_BYTE, 1'b0);
        send_column(8'h80, GAP_BYTE, 1'b1);
    endtask

    // Single-column alignments across the clip conditions
    task automatic test_clip_conditions();
        apply_setting(16'd300, 16'd1, 16'd250, 16'd200);
        send_run(COL_MATCH, 1, 1'b1);
        apply_setting(16'd300, 16'd5, 16'd299, 16'd200);
        send_run(COL_MISM, 1, 1'b1);
        apply_setting(16'd300, 16'd2, 16'd310, 16'd200);
        send_run(COL_INS, 1, 1'b1);
        apply_setting(16'd200, 16'd6, 16'd100, 16'd200);
        send_run(COL_DEL, 1, 1'b1);
        apply_setting(16'd100, 16'd6, 16'd50, 16'd200);
        send_run(COL_MATCH, 1, 1'b1);
        apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_run(COL_MATCH, 1, 1'b1);
        apply_setting(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFE);
        send_run(COL_MISM, 1, 1'b1);
        apply_setting(16'd2, 16'd2, 16'd0, 16'd1);
        send_run(COL_DEL, 1, 1'b1);
    endtask

    // Deletion run exactly at the skip threshold, closed by the last column
    task automatic test_long_deletions();
        apply_setting(16'd0, 16'd1, 16'd0, 16'd0);
        send_run(COL_MATCH, 1, 1'b0);
        send_run(COL_DEL, 100, 1'b1);
    endtask

    // Mostly well-formed alignments with random content, some noise
    task automatic test_random_alignments();
        int first;
        int len;
        int left;
        int chunk;
        t_col_shape shape;
        first = columns_sent;
        while (columns_sent - first < RANDOM_COLS) begin
            if ($urandom_range(0, 3) == 0) begin
                apply_setting(pick_reg_value(), pick_reg_value() | 16'd0, pick_reg_value(),
                              pick_reg_value());
                if (cfg_qstart == 16'd0) begin
                    apply_setting(cfg_qlen, 16'd1, cfg_qend, cfg_alen);
                end
            end
            src_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_run(COL_NOISE, $urandom_range(1, 8), 1'b1);
            end else begin
                len  = $urandom_range(1, 12);
                left = len;
                while (left > 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: shape = COL_MATCH;
                        3, 4:    shape = COL_MISM;
                        5, 6:    shape = COL_INS;
                        7, 8:    shape = COL_DEL;
                        default: shape = COL_BOTH_GAP;
                    endcase
                    chunk = $urandom_range(1, 4);
                    if (chunk > left) chunk = left;
                    send_run(shape, chunk, chunk == left);
                    left -= chunk;
                end
            end
        end
        src_gaps_on = 1'b1;
    endtask

    // Result side: random stalls with calm stretches in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!sink_stalls_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            i_ready   <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            calm_left <= $urandom_range(20, 60);
            i_ready   <= 1'b1;
        end else begin
            sink_gap = pick_gap();
            if (sink_gap > 0) begin
                stall_left <= sink_gap - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each completed output transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_cigar.size() == 0) begin
                $display("%0t: unexpected operation op_code %0d op_length %0d last_op %0d",
                         $time, o_op_code, o_op_length, o_last_op);
                errors++;
            end else begin
                checked_op = expected_cigar.pop_front();
                if (o_op_code !== checked_op.op_code) begin
                    $display("%0t: op_code expected %0d actual %0d",
                             $time, checked_op.op_code, o_op_code);
                    errors++;
                end
                if (o_op_length !== checked_op.op_length) begin
                    $display("%0t: op_length expected %0d actual %0d",
                             $time, checked_op.op_length, o_op_length);
                    errors++;
                end
                if (o_last_op !== checked_op.last_op) begin
                    $display("%0t: last_op expected %0d actual %0d",
                             $time, checked_op.last_op, o_last_op);
                    errors++;
                end
            end
            ops_checked++;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d operations outstanding",
                     $time, expected_cigar.size());
            $display("alignment_cigar_run_encoder regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_QUERY_LENGTH;
        i_cfg_data     <= 16'd0;
        i_valid        <= 1'b0;
        i_query_char   <= 8'd0;
        i_subject_char <= 8'd0;
        i_last_column  <= 1'b0;
        columns_sent   = 0;
        alignments_done  = 0;
        settings_applied = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        cfg_qlen       = 16'd0;
        cfg_qstart     = 16'd1;
        cfg_qend       = 16'd0;
        cfg_alen       = 16'd0;
        run_kind       = OP_CLIP;
        run_len        = 16'd0;
        in_alignment   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gap_rules();
        test_clip_conditions();
        test_long_deletions();
        test_random_alignments();
        settle();

        $display("covered %0d columns in %0d alignments under %0d register settings,",
                 columns_sent, alignments_done, settings_applied);
        $display("checked %0d operations incl. a deletion run at the skip threshold",
                 ops_checked);
        if (errors == 0) begin
            $display("alignment_cigar_run_encoder regression: pass");
        end else begin
            $display("alignment_cigar_run_encoder regression: fail");
        end
        $finish;
    end

endmodule
